@@ design/assert_macros.svh @@
// Assertion macros used by the rotation matrix design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RMGM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition in one cycle that must be followed by another in the next.
`define RMGM_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);

`endif

@@ design/rmgm_pkg.sv @@
// Types, constants and arithmetic step functions of the rotation matrix pipeline.
`default_nettype none

package rmgm_pkg;

	localparam int unsigned SQ_STEPS  = 64;
	localparam int unsigned DIV_STEPS = 32;

	localparam logic [30:0] MIN_EAST_NORM_RST = 31'd6554;
	localparam logic [31:0] Q30_ONE           = 32'h4000_0000;
	localparam logic [63:0] Q30_HALF64        = 64'h0000_0000_2000_0000;

	typedef struct packed {
		logic [127:0] rad;
		logic [66:0]  rem;
		logic [63:0]  root;
	} sqrt_t;

	typedef struct packed {
		logic [31:0] num;
		logic [65:0] rem;
		logic [64:0] den;
		logic [31:0] quo;
	} div_t;

	typedef struct packed {
		logic [2:0][63:0] hm;
		logic [2:0]       hneg;
		logic [2:0][31:0] amag;
		logic [2:0]       aneg;
		logic [2:0][31:0] e;
	} geo_t;

	typedef struct packed {
		logic [2:0]       hneg;
		logic [2:0]       aneg;
		logic [2:0][31:0] e;
		logic [31:0]      r_e;
		logic             ok;
	} geo2_t;

	typedef struct packed {
		logic [2:0][31:0] east;
		logic [2:0][31:0] north;
		logic [2:0][31:0] up;
		logic [31:0]      incl_cos;
		logic [31:0]      incl_sin;
		logic             vld;
	} res_t;

	typedef struct packed {
		res_t             r;
		logic [2:0][31:0] e;
		logic [31:0]      r_e;
	} mid_t;

	typedef struct packed {
		res_t       r;
		logic [1:0] neg;
	} tail_t;

	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] x);
		return x[63] ? (~x + 64'd1) : x;
	endfunction

	function automatic logic signed [63:0] mul_ss(input logic signed [31:0] x,
			input logic signed [31:0] y);
		return 64'(x) * 64'(y);
	endfunction

	function automatic logic [63:0] mul_uu(input logic [31:0] x, input logic [31:0] y);
		return 64'(x) * 64'(y);
	endfunction

	// One digit of the restoring square root: two radicand bits in, one root bit out.
	function automatic sqrt_t sqrt_step(input sqrt_t s);
		sqrt_t       o;
		logic [66:0] r;
		logic [66:0] t;
		r = {s.rem[64:0], s.rad[127:126]};
		t = {1'b0, s.root, 2'b01};
		o.rad = {s.rad[125:0], 2'b00};
		if (r >= t) begin
			o.rem  = r - t;
			o.root = {s.root[62:0], 1'b1};
		end else begin
			o.rem  = r;
			o.root = {s.root[62:0], 1'b0};
		end
		return o;
	endfunction

	// Sets up round(n / d) as floor((2n + d) / 2d); the quotient must fit in 32 bits.
	function automatic div_t div_init(input logic [94:0] n, input logic [63:0] d);
		div_t        o;
		logic [95:0] nn;
		nn    = {n, 1'b0} + {32'b0, d};
		o.num = nn[31:0];
		o.rem = {2'b00, nn[95:32]};
		o.den = {d, 1'b0};
		o.quo = '0;
		return o;
	endfunction

	function automatic div_t div_step(input div_t s);
		div_t        o;
		logic [65:0] r;
		r     = {s.rem[64:0], s.num[31]};
		o.num = {s.num[30:0], 1'b0};
		o.den = s.den;
		if (r >= {1'b0, s.den}) begin
			o.rem = r - {1'b0, s.den};
			o.quo = {s.quo[30:0], 1'b1};
		end else begin
			o.rem = r;
			o.quo = {s.quo[30:0], 1'b0};
		end
		return o;
	endfunction

	function automatic logic [31:0] sat_q30(input logic [31:0] q, input logic neg);
		logic [31:0] m;
		m = (q > Q30_ONE) ? Q30_ONE : q;
		return neg ? (~m + 32'd1) : m;
	endfunction

	// Q4.60 to Q2.30, magnitude rounded half away from zero, then saturated.
	function automatic logic [31:0] round_q30(input logic [63:0] v);
		logic [63:0] m;
		logic [63:0] r;
		logic [33:0] q;
		logic [31:0] s;
		m = mag64(v);
		r = m + Q30_HALF64;
		q = r[63:30];
		s = (q > {2'b00, Q30_ONE}) ? Q30_ONE : q[31:0];
		return v[63] ? (~s + 32'd1) : s;
	endfunction

endpackage

`default_nettype wire

@@ design/rotation_matrix_from_gravity_mag.sv @@
// Rotation matrix and inclination terms from gravity and geomagnetic vectors.
`default_nettype none
`include "assert_macros.svh"

// Fully pipelined: one beat of gravity and field vectors is taken every clock cycle while
// in_ready is high. Most of the pipeline depth lies in the 64-stage square
// root of the squared east norm and the two chains of 32 divider stages (normalisation, then
// the inclination terms). A two-entry output register lets the pipeline keep taking beats
// while a result waits; only when both entries are full does in_ready fall. The threshold
// min_east_norm (unsigned Q15.16, reset 0.1) may only be written while no beat is in flight.
module rotation_matrix_from_gravity_mag (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [30:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] grav_x,
	input  logic signed [31:0] grav_y,
	input  logic signed [31:0] grav_z,
	input  logic signed [31:0] mag_x,
	input  logic signed [31:0] mag_y,
	input  logic signed [31:0] mag_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] east_x,
	output logic signed [31:0] east_y,
	output logic signed [31:0] east_z,
	output logic signed [31:0] north_x,
	output logic signed [31:0] north_y,
	output logic signed [31:0] north_z,
	output logic signed [31:0] up_x,
	output logic signed [31:0] up_y,
	output logic signed [31:0] up_z,
	output logic signed [31:0] incl_cos,
	output logic signed [31:0] incl_sin,
	output logic               valid_res
);

	logic [30:0] min_east_norm_q;
	logic        en;
	logic        push;
	logic        out_v_q;
	logic        skid_v_q;
	rmgm_pkg::res_t out_q;
	rmgm_pkg::res_t skid_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s71;
	logic v_s104, v_s105, v_s106, v_s107, v_s108, v_s109, v_s142;

	logic [2:0][31:0]        a_s1, e_s1;
	logic signed [5:0][63:0] p_s2;
	logic [2:0][31:0]        amag_s2, emag_s2, e_s2;
	logic [2:0]              aneg_s2;
	logic [2:0][64:0]        hdiff;
	logic [2:0][63:0]        hm_s3;
	logic [2:0]              hneg_s3, aneg_s3;
	logic [2:0][31:0]        amag_s3, emag_s3, e_s3;
	logic [2:0][63:0]        hll_s4, hlh_s4, hhh_s4, asq_s4, esq_s4;
	rmgm_pkg::geo_t          geo_s4, geo_s5, geo_s6;
	logic [2:0][127:0]       sqh_s5;
	logic [63:0]             sa_s5, se_s5, sa_s6, se_s6;
	logic [127:0]            sh_s6;
	rmgm_pkg::sqrt_t [2:0]   sqrt_in;

	rmgm_pkg::sqrt_t [2:0] rt_s7  [rmgm_pkg::SQ_STEPS];
	rmgm_pkg::geo_t        geo_s7 [rmgm_pkg::SQ_STEPS];
	logic                  rv_s7  [rmgm_pkg::SQ_STEPS];

	rmgm_pkg::sqrt_t [2:0] rt_last;
	rmgm_pkg::geo_t        geo_last;
	rmgm_pkg::div_t [5:0]  dv_s71;
	rmgm_pkg::geo2_t       g2_s71;

	rmgm_pkg::div_t [5:0] dv_s72  [rmgm_pkg::DIV_STEPS];
	rmgm_pkg::geo2_t      g2_s72  [rmgm_pkg::DIV_STEPS];
	logic                 dvv_s72 [rmgm_pkg::DIV_STEPS];

	rmgm_pkg::mid_t          mid_d, mid_s104, mid_s105, mid_s106, mid_s107, mid_s108;
	rmgm_pkg::mid_t          mid_n;
	logic signed [5:0][63:0] mp_s105, dp_s107;
	logic signed [63:0]      dc_s108, ds_s108;
	rmgm_pkg::div_t [1:0]    dv_s109;
	rmgm_pkg::tail_t         tl_s109;

	rmgm_pkg::div_t [1:0] dw_s110  [rmgm_pkg::DIV_STEPS];
	rmgm_pkg::tail_t      tl_s110  [rmgm_pkg::DIV_STEPS];
	logic                 dwv_s110 [rmgm_pkg::DIV_STEPS];

	rmgm_pkg::res_t fin;
	rmgm_pkg::res_t res_s142;

	assign en       = !skid_v_q;
	assign in_ready = en;
	assign push     = en && v_s142;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_east_norm_q <= rmgm_pkg::MIN_EAST_NORM_RST;
		end else if (cfg_we) begin
			min_east_norm_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s71  <= 1'b0;
			v_s104 <= 1'b0;
			v_s105 <= 1'b0;
			v_s106 <= 1'b0;
			v_s107 <= 1'b0;
			v_s108 <= 1'b0;
			v_s109 <= 1'b0;
			v_s142 <= 1'b0;
		end else if (en) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s71  <= rv_s7[rmgm_pkg::SQ_STEPS-1];
			v_s104 <= dvv_s72[rmgm_pkg::DIV_STEPS-1];
			v_s105 <= v_s104;
			v_s106 <= v_s105;
			v_s107 <= v_s106;
			v_s108 <= v_s107;
			v_s109 <= v_s108;
			v_s142 <= dwv_s110[rmgm_pkg::DIV_STEPS-1];
		end
	end

	// Cross product E x A, then the exact squared norms.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hdiff[i] = {p_s2[2*i][63], p_s2[2*i]} - {p_s2[2*i+1][63], p_s2[2*i+1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= grav_x;
			a_s1[1] <= grav_y;
			a_s1[2] <= grav_z;
			e_s1[0] <= mag_x;
			e_s1[1] <= mag_y;
			e_s1[2] <= mag_z;

			p_s2[0] <= rmgm_pkg::mul_ss(e_s1[1], a_s1[2]);
			p_s2[1] <= rmgm_pkg::mul_ss(e_s1[2], a_s1[1]);
			p_s2[2] <= rmgm_pkg::mul_ss(e_s1[2], a_s1[0]);
			p_s2[3] <= rmgm_pkg::mul_ss(e_s1[0], a_s1[2]);
			p_s2[4] <= rmgm_pkg::mul_ss(e_s1[0], a_s1[1]);
			p_s2[5] <= rmgm_pkg::mul_ss(e_s1[1], a_s1[0]);
			for (int i = 0; i < 3; i++) begin
				amag_s2[i] <= rmgm_pkg::mag32(a_s1[i]);
				emag_s2[i] <= rmgm_pkg::mag32(e_s1[i]);
				aneg_s2[i] <= a_s1[i][31];
			end
			e_s2 <= e_s1;

			for (int i = 0; i < 3; i++) begin
				hneg_s3[i] <= hdiff[i][64];
				hm_s3[i]   <= hdiff[i][64] ? 64'(~hdiff[i] + 65'd1) : hdiff[i][63:0];
			end
			amag_s3 <= amag_s2;
			aneg_s3 <= aneg_s2;
			emag_s3 <= emag_s2;
			e_s3    <= e_s2;

			for (int i = 0; i < 3; i++) begin
				hll_s4[i] <= rmgm_pkg::mul_uu(hm_s3[i][31:0], hm_s3[i][31:0]);
				hlh_s4[i] <= rmgm_pkg::mul_uu(hm_s3[i][31:0], hm_s3[i][63:32]);
				hhh_s4[i] <= rmgm_pkg::mul_uu(hm_s3[i][63:32], hm_s3[i][63:32]);
				asq_s4[i] <= rmgm_pkg::mul_uu(amag_s3[i], amag_s3[i]);
				esq_s4[i] <= rmgm_pkg::mul_uu(emag_s3[i], emag_s3[i]);
			end
			geo_s4.hm   <= hm_s3;
			geo_s4.hneg <= hneg_s3;
			geo_s4.amag <= amag_s3;
			geo_s4.aneg <= aneg_s3;
			geo_s4.e    <= e_s3;

			for (int i = 0; i < 3; i++) begin
				sqh_s5[i] <= {hhh_s4[i], 64'b0} + {31'b0, hlh_s4[i], 33'b0}
					+ {64'b0, hll_s4[i]};
			end
			sa_s5  <= asq_s4[0] + asq_s4[1] + asq_s4[2];
			se_s5  <= esq_s4[0] + esq_s4[1] + esq_s4[2];
			geo_s5 <= geo_s4;

			sh_s6  <= sqh_s5[0] + sqh_s5[1] + sqh_s5[2];
			sa_s6  <= sa_s5;
			se_s6  <= se_s5;
			geo_s6 <= geo_s5;
		end
	end

	always_comb begin
		sqrt_in[0].rad  = sh_s6;
		sqrt_in[1].rad  = {64'b0, sa_s6};
		sqrt_in[2].rad  = {64'b0, se_s6};
		for (int l = 0; l < 3; l++) begin
			sqrt_in[l].rem  = '0;
			sqrt_in[l].root = '0;
		end
	end

	for (genvar k = 0; k < rmgm_pkg::SQ_STEPS; k++) begin : g_sqrt
		rmgm_pkg::sqrt_t [2:0] cur;
		rmgm_pkg::geo_t        cur_geo;
		logic                  cur_v;
		if (k == 0) begin : g_head
			assign cur     = sqrt_in;
			assign cur_geo = geo_s6;
			assign cur_v   = v_s6;
		end else begin : g_body
			assign cur     = rt_s7[k-1];
			assign cur_geo = geo_s7[k-1];
			assign cur_v   = rv_s7[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s7[k] <= 1'b0;
			end else if (en) begin
				rv_s7[k] <= cur_v;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					rt_s7[k][l] <= rmgm_pkg::sqrt_step(cur[l]);
				end
				geo_s7[k] <= cur_geo;
			end
		end
	end

	assign rt_last  = rt_s7[rmgm_pkg::SQ_STEPS-1];
	assign geo_last = geo_s7[rmgm_pkg::SQ_STEPS-1];

	// Threshold test and set-up of the six normalising divisions.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_s71[i]   <= rmgm_pkg::div_init({1'b0, geo_last.hm[i], 30'b0},
					rt_last[0].root);
				dv_s71[3+i] <= rmgm_pkg::div_init({33'b0, geo_last.amag[i], 30'b0},
					rt_last[1].root);
			end
			g2_s71.hneg <= geo_last.hneg;
			g2_s71.aneg <= geo_last.aneg;
			g2_s71.e    <= geo_last.e;
			g2_s71.r_e  <= rt_last[2].root[31:0];
			g2_s71.ok   <= (rt_last[0].root != '0)
				&& (rt_last[0].root[63:16] >= {17'b0, min_east_norm_q});
		end
	end

	for (genvar k = 0; k < rmgm_pkg::DIV_STEPS; k++) begin : g_div_norm
		rmgm_pkg::div_t [5:0] cur;
		rmgm_pkg::geo2_t      cur_g;
		logic                 cur_v;
		if (k == 0) begin : g_head
			assign cur   = dv_s71;
			assign cur_g = g2_s71;
			assign cur_v = v_s71;
		end else begin : g_body
			assign cur   = dv_s72[k-1];
			assign cur_g = g2_s72[k-1];
			assign cur_v = dvv_s72[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s72[k] <= 1'b0;
			end else if (en) begin
				dvv_s72[k] <= cur_v;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 6; l++) begin
					dv_s72[k][l] <= rmgm_pkg::div_step(cur[l]);
				end
				g2_s72[k] <= cur_g;
			end
		end
	end

	always_comb begin
		mid_d.r.north    = '0;
		mid_d.r.incl_cos = '0;
		mid_d.r.incl_sin = '0;
		mid_d.r.vld      = g2_s72[rmgm_pkg::DIV_STEPS-1].ok;
		mid_d.e          = g2_s72[rmgm_pkg::DIV_STEPS-1].e;
		mid_d.r_e        = g2_s72[rmgm_pkg::DIV_STEPS-1].r_e;
		for (int i = 0; i < 3; i++) begin
			mid_d.r.east[i] = rmgm_pkg::sat_q30(dv_s72[rmgm_pkg::DIV_STEPS-1][i].quo,
				g2_s72[rmgm_pkg::DIV_STEPS-1].hneg[i]);
			mid_d.r.up[i]   = rmgm_pkg::sat_q30(dv_s72[rmgm_pkg::DIV_STEPS-1][3+i].quo,
				g2_s72[rmgm_pkg::DIV_STEPS-1].aneg[i]);
		end
	end

	always_comb begin
		mid_n = mid_s105;
		for (int i = 0; i < 3; i++) begin
			mid_n.r.north[i] = rmgm_pkg::round_q30(mp_s105[2*i] - mp_s105[2*i+1]);
		end
	end

	// North = An x Hn, then the dot products with E and set-up of the two inclination divisions.
	always_ff @(posedge clk) begin
		if (en) begin
			mid_s104 <= mid_d;

			mp_s105[0] <= rmgm_pkg::mul_ss(mid_s104.r.up[1], mid_s104.r.east[2]);
			mp_s105[1] <= rmgm_pkg::mul_ss(mid_s104.r.up[2], mid_s104.r.east[1]);
			mp_s105[2] <= rmgm_pkg::mul_ss(mid_s104.r.up[2], mid_s104.r.east[0]);
			mp_s105[3] <= rmgm_pkg::mul_ss(mid_s104.r.up[0], mid_s104.r.east[2]);
			mp_s105[4] <= rmgm_pkg::mul_ss(mid_s104.r.up[0], mid_s104.r.east[1]);
			mp_s105[5] <= rmgm_pkg::mul_ss(mid_s104.r.up[1], mid_s104.r.east[0]);
			mid_s105   <= mid_s104;

			mid_s106 <= mid_n;

			for (int i = 0; i < 3; i++) begin
				dp_s107[i]   <= rmgm_pkg::mul_ss(mid_s106.e[i], mid_s106.r.north[i]);
				dp_s107[3+i] <= rmgm_pkg::mul_ss(mid_s106.e[i], mid_s106.r.up[i]);
			end
			mid_s107 <= mid_s106;

			dc_s108  <= dp_s107[0] + dp_s107[1] + dp_s107[2];
			ds_s108  <= dp_s107[3] + dp_s107[4] + dp_s107[5];
			mid_s108 <= mid_s107;

			dv_s109[0] <= rmgm_pkg::div_init({31'b0, rmgm_pkg::mag64(dc_s108)},
				{32'b0, mid_s108.r_e});
			dv_s109[1] <= rmgm_pkg::div_init({31'b0, rmgm_pkg::mag64(ds_s108)},
				{32'b0, mid_s108.r_e});
			tl_s109.r   <= mid_s108.r;
			tl_s109.neg <= {ds_s108[63], dc_s108[63]};
		end
	end

	for (genvar k = 0; k < rmgm_pkg::DIV_STEPS; k++) begin : g_div_incl
		rmgm_pkg::div_t [1:0] cur;
		rmgm_pkg::tail_t      cur_t;
		logic                 cur_v;
		if (k == 0) begin : g_head
			assign cur   = dv_s109;
			assign cur_t = tl_s109;
			assign cur_v = v_s109;
		end else begin : g_body
			assign cur   = dw_s110[k-1];
			assign cur_t = tl_s110[k-1];
			assign cur_v = dwv_s110[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dwv_s110[k] <= 1'b0;
			end else if (en) begin
				dwv_s110[k] <= cur_v;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 2; l++) begin
					dw_s110[k][l] <= rmgm_pkg::div_step(cur[l]);
				end
				tl_s110[k] <= cur_t;
			end
		end
	end

	always_comb begin
		fin          = tl_s110[rmgm_pkg::DIV_STEPS-1].r;
		fin.incl_cos = rmgm_pkg::sat_q30(dw_s110[rmgm_pkg::DIV_STEPS-1][0].quo,
			tl_s110[rmgm_pkg::DIV_STEPS-1].neg[0]);
		fin.incl_sin = rmgm_pkg::sat_q30(dw_s110[rmgm_pkg::DIV_STEPS-1][1].quo,
			tl_s110[rmgm_pkg::DIV_STEPS-1].neg[1]);
		if (!fin.vld) begin
			fin = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s142 <= fin;
		end
	end

	// Output register with a parking entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res_s142;
			end
		end else if (push) begin
			skid_q <= res_s142;
		end
	end

	assign out_valid = out_v_q;
	assign east_x    = $signed(out_q.east[0]);
	assign east_y    = $signed(out_q.east[1]);
	assign east_z    = $signed(out_q.east[2]);
	assign north_x   = $signed(out_q.north[0]);
	assign north_y   = $signed(out_q.north[1]);
	assign north_z   = $signed(out_q.north[2]);
	assign up_x      = $signed(out_q.up[0]);
	assign up_y      = $signed(out_q.up[1]);
	assign up_z      = $signed(out_q.up[2]);
	assign incl_cos  = $signed(out_q.incl_cos);
	assign incl_sin  = $signed(out_q.incl_sin);
	assign valid_res = out_q.vld;

	`RMGM_ASSERT(a_skid_behind_out, skid_v_q |-> out_v_q, "parked beat without an output beat")
	`RMGM_ASSERT(a_invalid_zero, (out_v_q && !out_q.vld) |-> (out_q.east == '0 && out_q.north == '0 && out_q.up == '0 && out_q.incl_cos == '0 && out_q.incl_sin == '0), "invalid result has nonzero fields")
	`RMGM_ASSERT_NEXT(a_skid_fill, out_v_q && !out_ready && !skid_v_q && push, skid_v_q, "stalled beat was not parked")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the gravity and field vector rotation matrix pipeline.
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		logic signed [31:0] g[3];
		logic signed [31:0] m[3];
	} sensor_t;

	typedef struct {
		logic signed [31:0] v[11];
		logic               vld;
	} orient_t;

	class rotation_scoreboard;
		logic [30:0] threshold;
		orient_t     expected[$];
		int          mismatches;
		int          checked;
		int          invalid_seen;
		string       names[11] = '{"east_x", "east_y", "east_z", "north_x", "north_y",
			"north_z", "up_x", "up_y", "up_z", "incl_cos", "incl_sin"};

		function new();
			threshold = rmgm_pkg::MIN_EAST_NORM_RST;
		endfunction

		static function logic [63:0] isqrt(logic [127:0] s);
			logic [63:0] y;
			logic [63:0] t;
			y = '0;
			for (int b = 63; b >= 0; b--) begin
				t = y | (64'd1 << b);
				if (128'(t) * 128'(t) <= s)
					y = t;
			end
			return y;
		endfunction

		static function logic [63:0] round_div(logic [127:0] num, logic [63:0] d);
			logic [191:0] n2;
			logic [191:0] den;
			logic [191:0] q;
			n2  = (192'(num) << 1) + 192'(d);
			den = 192'(d) << 1;
			q   = n2 / den;
			return q[63:0];
		endfunction

		static function longint clip(logic [63:0] m, bit neg);
			if (m > 64'd1073741824)
				m = 64'd1073741824;
			return neg ? -longint'(m) : longint'(m);
		endfunction

		static function logic [63:0] abs64(longint v);
			return v < 0 ? 64'(-v) : 64'(v);
		endfunction

		static function longint to_q30(longint v);
			return clip((abs64(v) + 64'd536870912) >> 30, v < 0);
		endfunction

		function void note_input(sensor_t it);
			longint             a[3];
			longint             e[3];
			longint             hn[3];
			longint             an[3];
			longint             mv[3];
			longint             dc;
			longint             ds;
			logic signed [64:0] p;
			logic signed [64:0] q;
			logic signed [64:0] h;
			logic [63:0]        hm[3];
			bit                 hneg[3];
			logic [127:0]       sh;
			logic [63:0]        rh;
			logic [63:0]        ra;
			logic [63:0]        re;
			logic [63:0]        sa;
			logic [63:0]        se;
			orient_t            r;
			for (int i = 0; i < 3; i++) begin
				a[i] = it.g[i];
				e[i] = it.m[i];
			end
			for (int i = 0; i < 3; i++) begin
				p = e[(i + 1) % 3] * a[(i + 2) % 3];
				q = e[(i + 2) % 3] * a[(i + 1) % 3];
				h = p - q;
				hneg[i] = h < 0;
				hm[i] = hneg[i] ? 64'(-h) : 64'(h);
			end
			for (int i = 0; i < 11; i++)
				r.v[i] = '0;
			r.vld = 1'b0;
			sh = 128'(hm[0]) * 128'(hm[0]) + 128'(hm[1]) * 128'(hm[1])
				+ 128'(hm[2]) * 128'(hm[2]);
			rh = isqrt(sh);
			if (rh == 0 || (rh >> 16) < 64'(threshold)) begin
				expected.push_back(r);
				return;
			end
			sa = '0;
			se = '0;
			for (int i = 0; i < 3; i++) begin
				sa += abs64(a[i]) * abs64(a[i]);
				se += abs64(e[i]) * abs64(e[i]);
			end
			ra = isqrt(128'(sa));
			re = isqrt(128'(se));
			for (int i = 0; i < 3; i++) begin
				hn[i] = clip(round_div(128'(hm[i]) << 30, rh), hneg[i]);
				an[i] = clip(round_div(128'(abs64(a[i])) << 30, ra), a[i] < 0);
			end
			mv[0] = to_q30(an[1] * hn[2] - an[2] * hn[1]);
			mv[1] = to_q30(an[2] * hn[0] - an[0] * hn[2]);
			mv[2] = to_q30(an[0] * hn[1] - an[1] * hn[0]);
			dc = e[0] * mv[0] + e[1] * mv[1] + e[2] * mv[2];
			ds = e[0] * an[0] + e[1] * an[1] + e[2] * an[2];
			for (int i = 0; i < 3; i++) begin
				r.v[i]     = hn[i][31:0];
				r.v[3 + i] = mv[i][31:0];
				r.v[6 + i] = an[i][31:0];
			end
			r.v[9]  = 32'(clip(round_div(128'(abs64(dc)), re), dc < 0));
			r.v[10] = 32'(clip(round_div(128'(abs64(ds)), re), ds < 0));
			r.vld   = 1'b1;
			expected.push_back(r);
		endfunction

		function void check_result(orient_t got);
			orient_t want;
			if (expected.size() == 0) begin
				$error("result beat with no expectation waiting");
				mismatches++;
				return;
			end
			want = expected.pop_front();
			checked++;
			if (!want.vld)
				invalid_seen++;
			for (int i = 0; i < 11; i++)
				if (got.v[i] !== want.v[i]) begin
					$error("%s expected %0d got %0d", names[i], want.v[i], got.v[i]);
					mismatches++;
				end
			if (got.vld !== want.vld) begin
				$error("valid_res expected %0d got %0d", want.vld, got.vld);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [30:0]        cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] grav_x, grav_y, grav_z, mag_x, mag_y, mag_z;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] east_x, east_y, east_z, north_x, north_y, north_z;
	logic signed [31:0] up_x, up_y, up_z, incl_cos, incl_sin;
	logic               valid_res;

	rotation_scoreboard orient_sb = new();
	int                 send_idle_pct;
	int                 recv_idle_pct;
	bit                 hold_req;
	int                 quiet_cycles;
	int                 sent;

	rotation_matrix_from_gravity_mag dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.grav_x(grav_x), .grav_y(grav_y), .grav_z(grav_z),
		.mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.east_x(east_x), .east_y(east_y), .east_z(east_z),
		.north_x(north_x), .north_y(north_y), .north_z(north_z),
		.up_x(up_x), .up_y(up_y), .up_z(up_z),
		.incl_cos(incl_cos), .incl_sin(incl_sin), .valid_res(valid_res)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		orient_t got;
		if (arst_n && out_valid && out_ready) begin
			got.v = '{east_x, east_y, east_z, north_x, north_y, north_z,
				up_x, up_y, up_z, incl_cos, incl_sin};
			got.vld = valid_res;
			orient_sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 5000) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic send_beat(sensor_t it);
		forever begin
			@(negedge clk);
			if ($urandom_range(99) >= send_idle_pct)
				break;
			in_valid <= 1'b0;
		end
		in_valid <= 1'b1;
		grav_x <= it.g[0];
		grav_y <= it.g[1];
		grav_z <= it.g[2];
		mag_x  <= it.m[0];
		mag_y  <= it.m[1];
		mag_z  <= it.m[2];
		do @(posedge clk); while (!in_ready);
		orient_sb.note_input(it);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (orient_sb.expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_threshold(logic [30:0] thr);
		drain();
		repeat (160) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= thr;
		@(negedge clk);
		cfg_we <= 1'b0;
		orient_sb.threshold = thr;
	endtask

	function automatic sensor_t make_vec(int lo_bits);
		sensor_t it;
		int      kind;
		int      k;
		kind = $urandom_range(9);
		for (int i = 0; i < 3; i++) begin
			if (kind <= 2) begin
				it.g[i] = $urandom;
				it.m[i] = $urandom;
			end else if (kind <= 5) begin
				it.g[i] = $signed(32'($urandom_range(0, 2 ** 21))) - 2 ** 20;
				it.m[i] = $signed(32'($urandom_range(0, 2 ** 22))) - 2 ** 21;
			end else if (kind <= 7) begin
				it.g[i] = $signed(32'($urandom_range(0, 2 ** lo_bits))) - 2 ** (lo_bits - 1);
				it.m[i] = $signed(32'($urandom_range(0, 2 ** lo_bits))) - 2 ** (lo_bits - 1);
			end else begin
				it.g[i] = $signed(32'($urandom_range(0, 2 ** 16))) - 2 ** 15;
				it.m[i] = '0;
			end
		end
		if (kind == 8) begin
			k = $urandom_range(8);
			for (int i = 0; i < 3; i++)
				it.m[i] = it.g[i] * (k - 4);
		end else if (kind == 9) begin
			k = $urandom_range(2);
			it.g[k] = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			it.m[(k + 1) % 3] = $urandom;
		end
		return it;
	endfunction

	function automatic sensor_t vec(int gx, int gy, int gz, int mx, int my, int mz);
		sensor_t it;
		it.g = '{gx, gy, gz};
		it.m = '{mx, my, mz};
		return it;
	endfunction

	initial begin
		sensor_t   directed[$];
		int        fails;
		logic [30:0] thr_list[4];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		{grav_x, grav_y, grav_z, mag_x, mag_y, mag_z} = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed = '{
			vec(0, 0, 0, 0, 0, 0),
			vec(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
				32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff),
			vec(32'sh80000000, 32'sh80000000, 32'sh80000000,
				32'sh80000000, 32'sh80000000, 32'sh80000000),
			vec(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
				32'sh7fffffff, 32'sh80000000, 32'sh7fffffff),
			vec(32'sh80000000, 0, 0, 0, 32'sh80000000, 0),
			vec(32'sh7fffffff, 0, 0, 0, 0, 32'sh80000000),
			vec(0, 0, 642252, 1310720, 327680, -2621440),
			vec(0, 0, -642252, 1310720, 327680, 2621440),
			vec(65536, 0, 0, 0, 65536, 0),
			vec(0, 65536, 0, 0, 0, -65536),
			vec(65536, 65536, 65536, 131072, 131072, 131072),
			vec(0, 0, 0, 65536, 65536, 65536),
			vec(65536, 0, 0, 0, 0, 0),
			vec(0, 0, 65536, 0, 6553, 0),
			vec(0, 0, 65536, 0, 6554, 0),
			vec(0, 0, 65536, 0, 6555, 0),
			vec(0, 0, 65536, -6554, 0, 0),
			vec(1, 0, 0, 0, 1, 0),
			vec(-3, 5, 7, 11, -13, 17),
			vec(32'sh7fffffff, 32'sh80000000, 1, -1, 32'sh7fffffff, 32'sh80000000)
		};
		send_idle_pct = 28;
		recv_idle_pct = 73;
		foreach (directed[i])
			send_beat(directed[i]);

		thr_list = '{31'd0, 31'h7fffffff, 31'($urandom_range(1, 20000)),
			rmgm_pkg::MIN_EAST_NORM_RST};
		for (int ph = 0; ph < 4; ph++) begin
			set_threshold(thr_list[ph]);
			send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 73 : 0;
			recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 28 : 0;
			for (int n = 0; n < 420; n++) begin
				if (ph == 1 && n == 200)
					drain();
				if (ph == 2 && n == 100)
					hold_req = 1'b1;
				send_beat(make_vec($urandom_range(12, 16)));
			end
		end
		drain();
		repeat (200) @(posedge clk);

		fails = orient_sb.mismatches + orient_sb.expected.size();
		$display("Run covered %0d beats in, %0d results checked, %0d of them invalid,",
			sent, orient_sb.checked, orient_sb.invalid_seen);
		$display("under four threshold settings and three idling patterns.");
		if (fails == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+design
design/rmgm_pkg.sv
design/rotation_matrix_from_gravity_mag.sv
bench/testbench.sv
